// ===== hw/rtl/otq_pkg.sv =====
`timescale 1ns / 1ps
package otq_pkg;
   localparam int TIME_W = 63;
   localparam int IVAL_W = 32;
   localparam int SLOT_W = 4;
   localparam int MAX_RESULTS = 16;

   localparam logic [1:0] MODE_ADD    = 2'd0;
   localparam logic [1:0] MODE_CANCEL = 2'd1;
   localparam logic [1:0] MODE_TICK   = 2'd2;

   localparam logic [1:0] EV_ADD     = 2'd0;
   localparam logic [1:0] EV_CANCEL  = 2'd1;
   localparam logic [1:0] EV_EXPIRED = 2'd2;
   localparam logic [1:0] EV_EMPTY   = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_INACTIVE = 2'd2;

   localparam logic [15:0] MIN_ARM_RESET = 16'd100;

   typedef struct packed {
      logic [1:0]        mode;
      logic [SLOT_W-1:0] slot_index;
      logic [TIME_W-1:0] new_expiration;
      logic [IVAL_W-1:0] reload_interval;
      logic              repeat_flag;
      logic [TIME_W-1:0] now_time;
   } req_type;

   typedef struct packed {
      logic [1:0]        event_kind;
      logic [1:0]        status;
      logic [SLOT_W-1:0] timer_slot;
      logic              earliest_changed;
      logic              next_valid;
      logic [TIME_W-1:0] next_expire;
      logic [TIME_W-1:0] arm_delay;
      logic              last_result;
   } rsp_type;
endpackage

// ===== hw/rtl/otq_if.sv =====
`timescale 1ns / 1ps
interface otq_req_if;
   import otq_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface otq_rsp_if;
   import otq_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface otq_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/ordered_timer_queue.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Payload
// req      in         mode, slot_index, new_expiration, reload_interval, repeat_flag, now_time
// rsp      out        event_kind, status, timer_slot, earliest_changed, next_valid,
//                     next_expire, arm_delay, last_result
// csr      in         min_arm_delay write data
// One comparator walks the slot table one slot per cycle. An add scans the table for the
// earliest expiry, then for a free slot, writes the timer if one is free and searches for
// the earliest again; a cancel clears the slot and searches for the earliest. A tick runs
// one selection scan per expired timer, one more scan when fewer than 16 expire, a reload
// pass, the earliest search and the arm-delay step, then delivers its results one by one.
// Reset is synchronous and clears the active bits and the sequencer; min_arm_delay
// returns to 100. A stalled result holds the sequencer; req is not ready while busy.
module ordered_timer_queue #(
   parameter int TIMER_SLOTS = 16
) (
   input logic clock,
   input logic reset,
   otq_req_if.sink   req,
   otq_rsp_if.source rsp,
   otq_csr_if.sink   csr
);
   import otq_pkg::*;
   localparam int IW = $clog2(TIMER_SLOTS);
   localparam int CW = $clog2(TIMER_SLOTS + 1);
   localparam int KW = 5;

   localparam logic [3:0] S_IDLE = 4'd0, S_ADDMIN = 4'd1, S_ADDFREE = 4'd2,
      S_ADDWR = 4'd3, S_SEL = 4'd4, S_SELEND = 4'd5, S_RELOAD = 4'd6,
      S_MIN = 4'd7, S_DELAY = 4'd8, S_OUT = 4'd9, S_CANCEL = 4'd10;

   logic [TIME_W-1:0] exp_mem [TIMER_SLOTS];
   logic [IVAL_W-1:0] ival_mem [TIMER_SLOTS];
   logic [TIMER_SLOTS-1:0] per_ff, active_ff, active_in, taken_ff, taken_in;

   logic [3:0] state_ff, state_in;
   req_type req_ff, req_in;
   logic [15:0] min_ff, min_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic any_ff, any_in;
   logic [TIME_W-1:0] best_ff, best_in;
   logic [IW-1:0] pick_ff, pick_in;
   logic [SLOT_W-1:0] order_ff [MAX_RESULTS];
   logic [KW-1:0] cnt_ff, cnt_in, k_ff, k_in;
   logic [1:0] status_ff, status_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic chg_ff, chg_in;
   logic [TIME_W-1:0] delay_ff, delay_in;
   logic rvalid_ff, rvalid_in;
   rsp_type rsp_ff, rsp_in;

   logic [IW-1:0] idx;
   logic [TIME_W-1:0] cur_exp;
   logic [TIME_W:0] sum;
   logic [TIME_W-1:0] diff;
   logic wr_exp, wr_add;
   logic [IW-1:0] wr_idx;
   logic [TIME_W-1:0] wr_val;

   assign idx = idx_ff[IW-1:0];
   assign cur_exp = exp_mem[idx];
   assign sum = {1'b0, req_ff.now_time} + {{(TIME_W-IVAL_W+1){1'b0}}, ival_mem[idx]};
   assign diff = best_ff - req_ff.now_time;
   assign req.ready = (state_ff == S_IDLE) && !rvalid_ff;
   assign csr.ready = 1'b1;
   assign rsp.valid = rvalid_ff;
   assign rsp.payload = rsp_ff;

   always_comb begin
      state_in = state_ff; req_in = req_ff; min_in = min_ff; idx_in = idx_ff;
      any_in = any_ff; best_in = best_ff; pick_in = pick_ff; cnt_in = cnt_ff;
      k_in = k_ff; status_in = status_ff; slot_in = slot_ff; chg_in = chg_ff;
      delay_in = delay_ff; rvalid_in = rvalid_ff; rsp_in = rsp_ff;
      active_in = active_ff; taken_in = taken_ff;
      wr_exp = 1'b0; wr_add = 1'b0; wr_idx = idx; wr_val = cur_exp;
      if (csr.valid) min_in = csr.data;
      if (rvalid_ff && rsp.ready) rvalid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               req_in = req.payload; idx_in = '0; any_in = 1'b0; best_in = '0;
               chg_in = 1'b0; status_in = ST_OK; slot_in = '0;
               cnt_in = '0; k_in = '0; taken_in = '0; any_in = 1'b0;
               unique case (req.payload.mode)
                  MODE_ADD:    state_in = S_ADDMIN;
                  MODE_CANCEL: state_in = S_CANCEL;
                  MODE_TICK:   state_in = S_SEL;
                  default:     state_in = S_IDLE;
               endcase
            end
         end
         S_CANCEL: begin
            slot_in = req_ff.slot_index;
            if ({{(IW+1){1'b0}}, req_ff.slot_index} < (SLOT_W+1+IW)'(TIMER_SLOTS)
                && active_ff[IW'(req_ff.slot_index)]) begin
               active_in[IW'(req_ff.slot_index)] = 1'b0;
            end else begin
               status_in = ST_INACTIVE;
            end
            idx_in = '0; any_in = 1'b0; state_in = S_MIN;
         end
         S_ADDMIN: begin
            if (active_ff[idx] && (!any_ff || cur_exp < best_ff)) begin
               best_in = cur_exp; any_in = 1'b1;
            end
            if (idx_ff == CW'(TIMER_SLOTS - 1)) begin
               idx_in = '0; state_in = S_ADDFREE;
            end else idx_in = idx_ff + 1'b1;
         end
         S_ADDFREE: begin
            if (!active_ff[idx]) begin
               state_in = S_ADDWR;
            end else if (idx_ff == CW'(TIMER_SLOTS - 1)) begin
               status_in = ST_FULL; idx_in = '0; state_in = S_MIN;
            end else idx_in = idx_ff + 1'b1;
         end
         S_ADDWR: begin
            wr_add = 1'b1; active_in[idx] = 1'b1;
            slot_in = SLOT_W'(idx);
            chg_in = !any_ff || (req_ff.new_expiration < best_ff);
            idx_in = '0; any_in = 1'b0; state_in = S_MIN;
         end
         S_SEL: begin
            if (active_ff[idx] && !taken_ff[idx] && cur_exp <= req_ff.now_time
                && (!any_ff || cur_exp < best_ff)) begin
               best_in = cur_exp; any_in = 1'b1; pick_in = idx;
            end
            if (idx_ff == CW'(TIMER_SLOTS - 1)) state_in = S_SELEND;
            else idx_in = idx_ff + 1'b1;
         end
         S_SELEND: begin
            idx_in = '0; any_in = 1'b0;
            if (any_ff) begin
               taken_in[pick_ff] = 1'b1;
               cnt_in = cnt_ff + 1'b1;
               state_in = (cnt_ff == KW'(MAX_RESULTS - 1)) ? S_RELOAD : S_SEL;
            end else state_in = S_RELOAD;
         end
         S_RELOAD: begin
            // Walk the table once, applying the reload or the free for each taken slot.
            if (taken_ff[idx]) begin
               if (per_ff[idx]) begin
                  wr_exp = 1'b1;
                  wr_val = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
               end else active_in[idx] = 1'b0;
            end
            if (idx_ff == CW'(TIMER_SLOTS - 1)) begin
               idx_in = '0; any_in = 1'b0; best_in = '0; state_in = S_MIN;
            end else idx_in = idx_ff + 1'b1;
         end
         S_MIN: begin
            if (active_ff[idx] && (!any_ff || cur_exp < best_ff)) begin
               best_in = cur_exp; any_in = 1'b1;
            end
            if (idx_ff == CW'(TIMER_SLOTS - 1)) state_in = S_DELAY;
            else idx_in = idx_ff + 1'b1;
         end
         S_DELAY: begin
            if (!any_ff) begin
               best_in = '0; delay_in = '0;
            end else begin
               delay_in = (best_ff > req_ff.now_time) ? diff : '0;
               if (((best_ff > req_ff.now_time) ? diff : '0) < {47'd0, min_ff})
                  delay_in = {47'd0, min_ff};
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rvalid_ff || rsp.ready) begin
               rvalid_in = 1'b1;
               rsp_in.status = status_ff;
               rsp_in.earliest_changed = 1'b0;
               rsp_in.next_valid = any_ff;
               rsp_in.next_expire = best_ff;
               rsp_in.arm_delay = delay_ff;
               rsp_in.last_result = 1'b1;
               rsp_in.timer_slot = slot_ff;
               unique case (req_ff.mode)
                  MODE_ADD: begin
                     rsp_in.event_kind = EV_ADD; rsp_in.earliest_changed = chg_ff;
                  end
                  MODE_CANCEL: rsp_in.event_kind = EV_CANCEL;
                  default: begin
                     if (cnt_ff == '0) begin
                        rsp_in.event_kind = EV_EMPTY; rsp_in.timer_slot = '0;
                     end else begin
                        rsp_in.event_kind = EV_EXPIRED;
                        rsp_in.timer_slot = order_ff[k_ff[SLOT_W-1:0]];
                        rsp_in.last_result = (k_ff == cnt_ff - 1'b1);
                     end
                  end
               endcase
               if (req_ff.mode == MODE_TICK && cnt_ff != '0 && k_ff != cnt_ff - 1'b1)
                  k_in = k_ff + 1'b1;
               else state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_add) begin
         exp_mem[idx] <= req_ff.new_expiration;
         ival_mem[idx] <= req_ff.reload_interval;
         per_ff[idx] <= req_ff.repeat_flag;
      end else if (wr_exp) exp_mem[wr_idx] <= wr_val;
      if (state_ff == S_SELEND && any_ff)
         order_ff[cnt_ff[SLOT_W-1:0]] <= SLOT_W'(pick_ff);
      req_ff <= req_in; idx_ff <= idx_in; any_ff <= any_in; best_ff <= best_in;
      pick_ff <= pick_in; k_ff <= k_in; status_ff <= status_in; slot_ff <= slot_in;
      chg_ff <= chg_in; delay_ff <= delay_in; rsp_ff <= rsp_in; taken_ff <= taken_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         state_ff <= S_IDLE; active_ff <= '0; rvalid_ff <= 1'b0; min_ff <= MIN_ARM_RESET;
      end else begin
         state_ff <= state_in; active_ff <= active_in; rvalid_ff <= rvalid_in;
         min_ff <= min_in;
      end
   end
endmodule

// ===== verif/ordered_timer_queue_tb.sv =====
`timescale 1ns / 1ps
module ordered_timer_queue_tb;
   import otq_pkg::*;

   localparam int SLOTS = 16;
   localparam logic [62:0] TIME_MAX = {63{1'b1}};
   localparam int IDLE_LIMIT = 20000;
   localparam logic [1:0] MODE_NONE = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   otq_req_if req_ch ();
   otq_rsp_if rsp_ch ();
   otq_csr_if csr_ch ();

   ordered_timer_queue #(.TIMER_SLOTS(SLOTS)) u_top (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source), .csr(csr_ch.sink)
   );

   always #5 clock = ~clock;

   // Predictor state.
   logic        tq_active [SLOTS];
   logic [62:0] tq_expiry [SLOTS];
   logic [31:0] tq_ival [SLOTS];
   logic        tq_periodic [SLOTS];
   logic [15:0] tq_min_arm;

   rsp_type expected_events [$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles = 0;
   int quiet_cycles = 0;

   function automatic logic find_earliest(output logic [62:0] when);
      logic any;
      any = 1'b0;
      when = '0;
      for (int i = 0; i < SLOTS; i++)
         if (tq_active[i] && (!any || tq_expiry[i] < when)) begin
            when = tq_expiry[i];
            any = 1'b1;
         end
      return any;
   endfunction

   function automatic rsp_type make_event(logic [1:0] kind, logic [1:0] st, logic [3:0] slot,
                                          logic changed, logic [62:0] now);
      rsp_type r;
      logic [62:0] nxt;
      logic [62:0] dly;
      r.next_valid = find_earliest(nxt);
      dly = '0;
      if (r.next_valid) begin
         dly = (nxt > now) ? nxt - now : '0;
         if (dly < {47'd0, tq_min_arm}) dly = {47'd0, tq_min_arm};
      end
      r.event_kind = kind;
      r.status = st;
      r.timer_slot = slot;
      r.earliest_changed = changed;
      r.next_expire = nxt;
      r.arm_delay = dly;
      r.last_result = 1'b0;
      return r;
   endfunction

   task automatic predict_timer_step(input req_type t);
      rsp_type ev [$];
      logic [62:0] first;
      logic any;
      int free_slot;
      logic taken [SLOTS];
      int order [$];
      int pick;
      logic [63:0] sum;
      if (t.mode == MODE_ADD) begin
         any = find_earliest(first);
         free_slot = -1;
         for (int i = SLOTS - 1; i >= 0; i--)
            if (!tq_active[i]) free_slot = i;
         if (free_slot < 0) begin
            ev.insert(ev.size(), make_event(EV_ADD, ST_FULL, 4'd0, 1'b0, t.now_time));
         end else begin
            tq_active[free_slot] = 1'b1;
            tq_expiry[free_slot] = t.new_expiration;
            tq_ival[free_slot] = t.reload_interval;
            tq_periodic[free_slot] = t.repeat_flag;
            ev.insert(ev.size(), make_event(EV_ADD, ST_OK, free_slot[3:0],
                                            !any || t.new_expiration < first, t.now_time));
         end
      end else if (t.mode == MODE_CANCEL) begin
         if (tq_active[t.slot_index]) begin
            tq_active[t.slot_index] = 1'b0;
            ev.insert(ev.size(),
                      make_event(EV_CANCEL, ST_OK, t.slot_index, 1'b0, t.now_time));
         end else begin
            ev.insert(ev.size(),
                      make_event(EV_CANCEL, ST_INACTIVE, t.slot_index, 1'b0, t.now_time));
         end
      end else if (t.mode == MODE_TICK) begin
         for (int i = 0; i < SLOTS; i++) taken[i] = 1'b0;
         while (order.size() < MAX_RESULTS) begin
            pick = -1;
            for (int i = 0; i < SLOTS; i++)
               if (tq_active[i] && !taken[i] && tq_expiry[i] <= t.now_time &&
                   (pick < 0 || tq_expiry[i] < tq_expiry[pick]))
                  pick = i;
            if (pick < 0) break;
            taken[pick] = 1'b1;
            order.insert(order.size(), pick);
         end
         foreach (order[k]) begin
            if (tq_periodic[order[k]]) begin
               sum = {1'b0, t.now_time} + {32'd0, tq_ival[order[k]]};
               tq_expiry[order[k]] = sum[63] ? TIME_MAX : sum[62:0];
            end else begin
               tq_active[order[k]] = 1'b0;
            end
         end
         if (order.size() == 0)
            ev.insert(ev.size(), make_event(EV_EMPTY, ST_OK, 4'd0, 1'b0, t.now_time));
         foreach (order[k])
            ev.insert(ev.size(),
                      make_event(EV_EXPIRED, ST_OK, order[k][3:0], 1'b0, t.now_time));
      end
      if (ev.size() > 0) ev[ev.size() - 1].last_result = 1'b1;
      foreach (ev[k]) expected_events.insert(expected_events.size(), ev[k]);
   endtask

   // Stimulus side. The predictor runs on acceptance, so its order matches the block's.
   task automatic send_item(input req_type t);
      req_ch.valid <= 1'b1;
      req_ch.payload <= t;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_timer_step(t);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
   endtask

   task automatic drain_and_settle();
      req_ch.valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (3 * SLOTS + 8) @(posedge clock);
   endtask

   task automatic write_min_arm(input logic [15:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.data <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      tq_min_arm = value;
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type timer_item(logic [1:0] m, logic [3:0] s, logic [62:0] e,
                                          logic [31:0] iv, logic rp, logic [62:0] n);
      req_type t;
      t.mode = m;
      t.slot_index = s;
      t.new_expiration = e;
      t.reload_interval = iv;
      t.repeat_flag = rp;
      t.now_time = n;
      return t;
   endfunction

   function automatic logic [62:0] rand_time63();
      return 63'({$urandom(), $urandom()} >> 1);
   endfunction

   // Mostly timers around a moving clock, so ticks actually expire some of them.
   function automatic req_type random_item(inout logic [62:0] clk_now);
      int r;
      logic [62:0] e;
      logic [31:0] iv;
      r = $urandom_range(99);
      clk_now = clk_now + $urandom_range(400);
      e = clk_now + $urandom_range(600);
      iv = $urandom_range(500);
      if ($urandom_range(19) == 0) e = rand_time63();
      if ($urandom_range(19) == 0) iv = $urandom();
      if (r < 45)
         return timer_item(MODE_ADD, 4'($urandom()), e, iv, 1'($urandom()), clk_now);
      else if (r < 60)
         return timer_item(MODE_CANCEL, 4'($urandom()), rand_time63(), $urandom(),
                           1'($urandom()), clk_now);
      else if (r < 97)
         return timer_item(MODE_TICK, 4'($urandom()), rand_time63(), $urandom(),
                           1'($urandom()), clk_now);
      return timer_item(MODE_NONE, 4'($urandom()), rand_time63(), $urandom(),
                        1'($urandom()), rand_time63());
   endfunction

   typedef struct {
      req_type stim;
      logic    has_gold;
      rsp_type gold;
   } directed_row_type;

   directed_row_type directed_rows [$];

   function automatic rsp_type gold_event(logic [1:0] kind, logic [1:0] st, logic [3:0] slot,
                                          logic nv, logic [62:0] nx, logic [62:0] dl);
      rsp_type r;
      r.event_kind = kind;
      r.status = st;
      r.timer_slot = slot;
      r.earliest_changed = 1'b0;
      r.next_valid = nv;
      r.next_expire = nx;
      r.arm_delay = dl;
      r.last_result = 1'b1;
      return r;
   endfunction

   function automatic void add_row(req_type t, logic g = 1'b0, rsp_type gv = '0);
      directed_row_type row;
      row.stim = t;
      row.has_gold = g;
      row.gold = gv;
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   // Response side: random back-pressure plus an optional long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_events.size() == 0) begin
            $display("%0t: unexpected transaction %p", $time, rsp_ch.payload);
            errors++;
         end else begin
            if (rsp_ch.payload !== expected_events[0]) begin
               $display("%0t: mismatch expected %p actual %p", $time, expected_events[0],
                        rsp_ch.payload);
               errors++;
            end
            void'(expected_events.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready) || hold_cycles > 0)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      logic [62:0] clk_now;
      logic [15:0] arm_settings [4];
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      csr_ch.valid = 1'b0;
      csr_ch.data = '0;
      for (int i = 0; i < SLOTS; i++) begin
         tq_active[i] = 1'b0;
         tq_expiry[i] = '0;
         tq_ival[i] = '0;
         tq_periodic[i] = 1'b0;
      end
      tq_min_arm = MIN_ARM_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows: empty table, extremes, full table, idle cancels, overflow, overload.
      add_row(timer_item(MODE_TICK, 4'hF, TIME_MAX, '1, 1'b1, TIME_MAX), 1'b1,
              gold_event(EV_EMPTY, ST_OK, 4'd0, 1'b0, '0, '0));
      add_row(timer_item(MODE_CANCEL, 4'd15, '0, '0, 1'b0, '0), 1'b1,
              gold_event(EV_CANCEL, ST_INACTIVE, 4'd15, 1'b0, '0, '0));
      add_row(timer_item(MODE_NONE, 4'd0, '0, '0, 1'b0, '0));
      add_row(timer_item(MODE_ADD, 4'd0, TIME_MAX, '1, 1'b1, '0));
      add_row(timer_item(MODE_ADD, 4'd0, 63'd50, 32'd0, 1'b1, 63'd1000));
      for (int i = 0; i < 14; i++)
         add_row(timer_item(MODE_ADD, 4'(i), 63'(10 * i), 32'(i), 1'(i % 2), 63'd20));
      add_row(timer_item(MODE_ADD, 4'd0, '0, '0, 1'b0, '0), 1'b1,
              gold_event(EV_ADD, ST_FULL, 4'd0, 1'b1, '0, 63'd100));
      add_row(timer_item(MODE_TICK, 4'd0, '0, '0, 1'b0, TIME_MAX));
      add_row(timer_item(MODE_CANCEL, 4'd1, '0, '0, 1'b0, 63'd5));
      add_row(timer_item(MODE_TICK, 4'd0, '0, '0, 1'b0, 63'd2000));

      foreach (directed_rows[k]) begin
         if (directed_rows[k].has_gold) begin
            send_item(directed_rows[k].stim);
            // Cross-check the predicted transaction against the typed-in one.
            if (expected_events.size() != 0 &&
                expected_events[expected_events.size() - 1] !== directed_rows[k].gold) begin
               $display("%0t: mismatch expected %p actual %p", $time, directed_rows[k].gold,
                        expected_events[expected_events.size() - 1]);
               errors++;
            end
         end else begin
            send_item(directed_rows[k].stim);
         end
      end
      drain_and_settle();

      // Long receiver hold-off while requests keep coming, then a full drain.
      hold_cycles = 400;
      clk_now = 63'd1000;
      for (int i = 0; i < 12; i++) send_item(random_item(clk_now));
      drain_and_settle();

      arm_settings[0] = 16'd0;
      arm_settings[1] = 16'hFFFF;
      arm_settings[2] = 16'($urandom());
      arm_settings[3] = 16'd1;
      for (int phase = 0; phase < 4; phase++) begin
         write_min_arm(arm_settings[phase]);
         // Clear out the table so each phase starts from a known fill.
         for (int s = 0; s < SLOTS; s++)
            send_item(timer_item(MODE_CANCEL, 4'(s), '0, '0, 1'b0, clk_now));
         case (phase)
            0: begin
               send_idle_pct = 7;
               recv_idle_pct = 84;
            end
            1: begin
               send_idle_pct = 84;
               recv_idle_pct = 7;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int i = 0; i < 30; i++) send_item(random_item(clk_now));
         drain_and_settle();
      end

      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

// ===== files.f =====
hw/rtl/otq_pkg.sv
hw/rtl/otq_if.sv
hw/rtl/ordered_timer_queue.sv
verif/ordered_timer_queue_tb.sv
